### sv/ifd_pkg.sv
// shared types, codes and tables for the imu fall detector
`default_nettype none
package ifd_pkg;

  // multiply-accumulate operand pairs
  localparam logic [3:0] MAC_AX  = 4'd0;
  localparam logic [3:0] MAC_AY  = 4'd1;
  localparam logic [3:0] MAC_AZ  = 4'd2;
  localparam logic [3:0] MAC_GX  = 4'd3;
  localparam logic [3:0] MAC_GY  = 4'd4;
  localparam logic [3:0] MAC_GZ  = 4'd5;
  localparam logic [3:0] MAC_LP  = 4'd6;
  localparam logic [3:0] MAC_LPA = 4'd7;
  localparam logic [3:0] MAC_PI  = 4'd8;
  localparam logic [3:0] MAC_RO  = 4'd9;
  localparam logic [3:0] MAC_BL  = 4'd10;
  localparam logic [3:0] MAC_BT  = 4'd11;

  // square root operand and destination
  localparam logic [1:0] ROOT_ACCEL = 2'd0;
  localparam logic [1:0] ROOT_GYRO  = 2'd1;
  localparam logic [1:0] ROOT_YZ    = 2'd2;
  localparam logic [1:0] ROOT_TILT  = 2'd3;

  localparam logic CORD_PITCH = 1'b0;
  localparam logic CORD_ROLL  = 1'b1;

  localparam logic [1:0] CANCEL_NONE        = 2'd0;
  localparam logic [1:0] CANCEL_MOTION      = 2'd1;
  localparam logic [1:0] CANCEL_SLOW_ROT    = 2'd2;
  localparam logic [1:0] CANCEL_SMALL_ANGLE = 2'd3;

  // register map
  localparam logic [2:0] REG_FREEFALL     = 3'd0;
  localparam logic [2:0] REG_IMPACT       = 3'd1;
  localparam logic [2:0] REG_IMPACT_AFTER = 3'd2;
  localparam logic [2:0] REG_PEAK_ROT     = 3'd3;
  localparam logic [2:0] REG_ANGLE_CHANGE = 3'd4;
  localparam logic [2:0] REG_ACCEL_SWING  = 3'd5;
  localparam logic [2:0] REG_ANGLE_SWING  = 3'd6;

  localparam int ROOT_IN_W  = 48;
  localparam int ROOT_OUT_W = 24;
  localparam int CORD_W     = 28;
  localparam int ANGLE_Z_W  = 25;

  typedef struct packed {
    logic [15:0] freefall_level;
    logic [15:0] impact_level;
    logic [15:0] impact_after_freefall_level;
    logic [15:0] peak_rotation_level;
    logic [14:0] angle_change_level;
    logic [15:0] accel_swing_limit;
    logic [14:0] angle_swing_limit;
  } cfg_t;

  typedef struct packed {
    logic       in_load;
    logic       mac_en;
    logic       acc_clr;
    logic [3:0] mac_sel;
    logic       root_start;
    logic [1:0] root_sel;
    logic       cord_start;
    logic       cord_sel;
    logic       lp_write;
    logic       decide;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic cord_done;
    logic out_free;
  } stat_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_step(input logic [4:0] idx);
    case (idx)
      5'd0:  return 22'd2949120;
      5'd1:  return 22'd1740967;
      5'd2:  return 22'd919879;
      5'd3:  return 22'd466945;
      5'd4:  return 22'd234379;
      5'd5:  return 22'd117304;
      5'd6:  return 22'd58666;
      5'd7:  return 22'd29335;
      5'd8:  return 22'd14668;
      5'd9:  return 22'd7334;
      5'd10: return 22'd3667;
      5'd11: return 22'd1833;
      5'd12: return 22'd917;
      5'd13: return 22'd458;
      5'd14: return 22'd229;
      5'd15: return 22'd115;
      5'd16: return 22'd57;
      5'd17: return 22'd29;
      5'd18: return 22'd14;
      5'd19: return 22'd7;
      5'd20: return 22'd4;
      5'd21: return 22'd2;
      5'd22: return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

### sv/ifd_isqrt.sv
// serial floor square root, one result bit per cycle
`default_nettype none
module ifd_isqrt import ifd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [ROOT_IN_W-1:0]  radicand,
  output logic                       done,
  output logic [ROOT_OUT_W-1:0]      root
);

  logic [ROOT_IN_W-1:0] rem;
  logic [ROOT_IN_W-1:0] res;
  logic [ROOT_IN_W-1:0] bitm;
  logic [ROOT_IN_W-1:0] trial;
  logic [4:0]           cnt;
  logic                 run;

  assign trial = res + bitm;
  assign root  = res[ROOT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == 5'(ROOT_OUT_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitm <= {2'b01, {(ROOT_IN_W-2){1'b0}}};
      cnt  <= '0;
    end else if (run) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + 5'd1;
    end
  end

endmodule
`default_nettype wire

### sv/ifd_cordic.sv
// vectoring cordic atan2, one rotation per cycle, result in 1/128 degree
`default_nettype none
module ifd_cordic import ifd_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [CORD_W-1:0] y_in,
  input  wire logic signed [CORD_W-1:0] x_in,
  output logic                          done,
  output logic signed [15:0]            angle
);

  logic signed [CORD_W-1:0]    x;
  logic signed [CORD_W-1:0]    y;
  logic signed [ANGLE_Z_W-1:0] z;
  logic signed [CORD_W-1:0]    xs;
  logic signed [CORD_W-1:0]    ys;
  logic signed [ANGLE_Z_W-1:0] step;
  logic [ANGLE_Z_W-1:0]        mag;
  logic [ANGLE_Z_W-1:0]        rnd;
  logic [4:0]                  i;
  logic                        run;
  logic                        zero;

  assign xs   = x >>> i;
  assign ys   = y >>> i;
  assign step = $signed({3'b000, atan_step(i)});

  // round half away from zero from 1/65536 to 1/128 degree
  assign mag   = z[ANGLE_Z_W-1] ? 25'(-z) : 25'(z);
  assign rnd   = (mag + 25'd256) >> 9;
  assign angle = zero ? 16'sd0 :
                 (z[ANGLE_Z_W-1] ? -$signed(rnd[15:0]) : $signed(rnd[15:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && i == 5'(STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero <= (x_in == '0) && (y_in == '0);
      i    <= '0;
      // fold the left half plane by a quarter turn
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          z <= 25'sd5898240;
        end else begin
          x <= -y_in;
          y <= x_in;
          z <= -25'sd5898240;
        end
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (run) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step;
      end
      i <= i + 5'd1;
    end
  end

endmodule
`default_nettype wire

### sv/ifd_dp.sv
// datapath: sample registers, shared multiplier, root and cordic units, decision logic
`default_nettype none
module ifd_dp import ifd_pkg::*; #(
  parameter int PEAK_WINDOW_MS   = 500,
  parameter int DECIDE_MS        = 2500,
  parameter int FREEFALL_HOLD_MS = 1000,
  parameter int CORDIC_STEPS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] gyro_x,
  input  wire logic signed [15:0] gyro_y,
  input  wire logic signed [15:0] gyro_z,
  input  wire logic [31:0]        time_ms,
  input  wire logic               manual_mode,
  input  wire logic               clear_alarm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    fall_confirmed,
  output logic                    fall_event,
  output logic                    impact_active,
  output logic                    freefall_active,
  output logic                    immobile,
  output logic [15:0]             filtered_accel,
  output logic [14:0]             tilt_angle,
  output logic [14:0]             baseline_angle,
  output logic [1:0]              cancel_reason
);

  // captured sample
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic [31:0]        now;
  logic               manual_r;
  logic               clr_r;

  // per-sample intermediates
  logic [15:0]           accel;
  logic [15:0]           gyro;
  logic [ROOT_OUT_W-1:0] yz;
  logic signed [15:0]    pitch;
  logic signed [15:0]    roll;
  logic [14:0]           tilt;
  logic [33:0]           acc;

  // detector state
  logic [15:0] lp;
  logic [14:0] baseline;
  logic [15:0] rotation_peak;
  logic [15:0] sa_max, sa_min;
  logic [14:0] sg_max, sg_min;
  logic        swing_tracking, impact_pending, fall_latched, freefall_seen;
  logic [31:0] freefall_stamp, impact_stamp;

  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  logic [33:0]        lp_sum;

  logic [ROOT_IN_W-1:0]  radicand;
  logic                  root_done;
  logic [ROOT_OUT_W-1:0] root;
  logic signed [CORD_W-1:0] cy, cx;
  logic                  cord_done;
  logic signed [15:0]    cord_angle;

  // decision values
  logic        lat, pend, trk, ffs, evt, still, quiet;
  logic [31:0] ffst, imst, dt;
  logic [15:0] peak, amax, amin, ga;
  logic [14:0] gmax, gmin, gb, bl, diff;
  logic [1:0]  cancel;
  logic [33:0] bl_sum;

  always_comb begin
    case (cmd.mac_sel)
      MAC_AX:  begin ma = 18'(ax);    mb = 18'(ax);    end
      MAC_AY:  begin ma = 18'(ay);    mb = 18'(ay);    end
      MAC_AZ:  begin ma = 18'(az);    mb = 18'(az);    end
      MAC_GX:  begin ma = 18'(gx);    mb = 18'(gx);    end
      MAC_GY:  begin ma = 18'(gy);    mb = 18'(gy);    end
      MAC_GZ:  begin ma = 18'(gz);    mb = 18'(gz);    end
      MAC_LP:  begin ma = 18'sd55706; mb = $signed({2'b00, lp});    end
      MAC_LPA: begin ma = 18'sd9830;  mb = $signed({2'b00, accel}); end
      MAC_PI:  begin ma = 18'(pitch); mb = 18'(pitch); end
      MAC_RO:  begin ma = 18'(roll);  mb = 18'(roll);  end
      MAC_BL:  begin ma = 18'sd62259; mb = $signed({3'b000, baseline}); end
      MAC_BT:  begin ma = 18'sd3277;  mb = $signed({3'b000, tilt});     end
      default: begin ma = '0;         mb = '0;         end
    endcase
  end

  assign prod   = ma * mb;
  assign lp_sum = acc + 34'd32768;
  assign bl_sum = acc + 34'd32768;

  assign radicand = (cmd.root_sel == ROOT_YZ) ? {acc[31:0], 16'h0000}
                                              : {16'h0000, acc[31:0]};

  ifd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    if (cmd.cord_sel == CORD_PITCH) begin
      cy = -CORD_W'($signed({ax, 8'h00}));
      cx = $signed({{(CORD_W-ROOT_OUT_W){1'b0}}, yz});
    end else begin
      cy = CORD_W'($signed({ay, 8'h00}));
      cx = CORD_W'($signed({az, 8'h00}));
    end
  end

  ifd_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cord_start),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cord_done),
    .angle (cord_angle)
  );

  assign stat.root_done = root_done;
  assign stat.cord_done = cord_done;
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ax       <= accel_x;
      ay       <= accel_y;
      az       <= accel_z;
      gx       <= gyro_x;
      gy       <= gyro_y;
      gz       <= gyro_z;
      now      <= time_ms;
      manual_r <= manual_mode;
      clr_r    <= clear_alarm;
    end
    if (cmd.mac_en) begin
      acc <= (cmd.acc_clr ? 34'd0 : acc) + prod[33:0];
    end
    if (root_done) begin
      case (cmd.root_sel)
        ROOT_ACCEL: accel <= root[15:0];
        ROOT_GYRO:  gyro  <= root[15:0];
        ROOT_YZ:    yz    <= root;
        default:    tilt  <= (root > 24'd32767) ? 15'd32767 : root[14:0];
      endcase
    end
    if (cord_done) begin
      if (cmd.cord_sel == CORD_PITCH) begin
        pitch <= cord_angle;
      end else begin
        roll <= cord_angle;
      end
    end
  end

  // one sample's decision, in program order
  always_comb begin
    lat    = fall_latched   & ~clr_r;
    pend   = impact_pending & ~clr_r;
    trk    = swing_tracking & ~clr_r;
    ffs    = freefall_seen;
    ffst   = freefall_stamp;
    imst   = impact_stamp;
    peak   = rotation_peak;
    amax   = sa_max;
    amin   = sa_min;
    gmax   = sg_max;
    gmin   = sg_min;
    bl     = baseline;
    evt    = 1'b0;
    cancel = CANCEL_NONE;
    dt     = '0;
    ga     = '0;
    gb     = '0;
    quiet  = 1'b0;
    diff   = '0;

    if (!pend && !lat && accel > 16'd6553 && accel < 16'd9831 && gyro < 16'd3275) begin
      bl = bl_sum[30:16];
    end

    still = !manual_r && lp > 16'd7536 && lp < 16'd8848 && !pend && !lat;

    if (!lat) begin
      if (accel < cfg.freefall_level) begin
        ffs  = 1'b1;
        ffst = now;
      end
      if (ffs && (now - ffst) > 32'(FREEFALL_HOLD_MS)) begin
        ffs = 1'b0;
      end
      if (!pend && (accel > cfg.impact_level ||
                    (ffs && accel > cfg.impact_after_freefall_level))) begin
        pend = 1'b1;
        imst = now;
        ffs  = 1'b0;
        peak = gyro;
        trk  = 1'b0;
      end
    end

    if (pend && !lat) begin
      dt = now - imst;
      if (dt <= 32'(PEAK_WINDOW_MS) && gyro > peak) begin
        peak = gyro;
      end
      if (dt > 32'(PEAK_WINDOW_MS) && !trk) begin
        trk  = 1'b1;
        amax = lp;
        amin = lp;
        gmax = tilt;
        gmin = tilt;
      end
      if (trk) begin
        if (lp > amax) amax = lp;
        if (lp < amin) amin = lp;
        if (tilt > gmax) gmax = tilt;
        if (tilt < gmin) gmin = tilt;
      end
      if (dt > 32'(DECIDE_MS)) begin
        ga    = (amax > amin) ? amax - amin : 16'd0;
        gb    = (gmax > gmin) ? gmax - gmin : 15'd0;
        quiet = ga < cfg.accel_swing_limit && gb < cfg.angle_swing_limit &&
                lp > 16'd5734 && lp < 16'd10650;
        diff  = (tilt > bl) ? tilt - bl : bl - tilt;
        if (!quiet) begin
          cancel = CANCEL_MOTION;
        end else if (peak <= cfg.peak_rotation_level) begin
          cancel = CANCEL_SLOW_ROT;
        end else if (diff > cfg.angle_change_level) begin
          lat = 1'b1;
          evt = 1'b1;
        end else begin
          cancel = CANCEL_SMALL_ANGLE;
        end
        if (cancel != CANCEL_NONE) begin
          pend = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp             <= 16'd8192;
      baseline       <= '0;
      rotation_peak  <= '0;
      sa_max         <= '0;
      sa_min         <= '0;
      sg_max         <= '0;
      sg_min         <= '0;
      swing_tracking <= 1'b0;
      impact_pending <= 1'b0;
      fall_latched   <= 1'b0;
      freefall_seen  <= 1'b0;
      freefall_stamp <= '0;
      impact_stamp   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.lp_write) begin
        lp <= lp_sum[31:16];
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.decide) begin
        baseline       <= bl;
        rotation_peak  <= peak;
        sa_max         <= amax;
        sa_min         <= amin;
        sg_max         <= gmax;
        sg_min         <= gmin;
        swing_tracking <= trk;
        impact_pending <= pend;
        fall_latched   <= lat;
        freefall_seen  <= ffs;
        freefall_stamp <= ffst;
        impact_stamp   <= imst;
        out_valid      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      fall_confirmed  <= lat;
      fall_event      <= evt;
      impact_active   <= pend;
      freefall_active <= ffs;
      immobile        <= still;
      filtered_accel  <= lp;
      tilt_angle      <= tilt;
      baseline_angle  <= bl;
      cancel_reason   <= cancel;
    end
  end

endmodule
`default_nettype wire

### sv/ifd_ctrl.sv
// controller: steps one sample through the datapath
`default_nettype none
module ifd_ctrl import ifd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  localparam logic [4:0] P_IDLE = 5'd0;
  localparam logic [4:0] P_AX   = 5'd1;
  localparam logic [4:0] P_AY   = 5'd2;
  localparam logic [4:0] P_AZ   = 5'd3;
  localparam logic [4:0] P_RA   = 5'd4;
  localparam logic [4:0] P_GX   = 5'd5;
  localparam logic [4:0] P_GY   = 5'd6;
  localparam logic [4:0] P_GZ   = 5'd7;
  localparam logic [4:0] P_RG   = 5'd8;
  localparam logic [4:0] P_YY   = 5'd9;
  localparam logic [4:0] P_YZ   = 5'd10;
  localparam logic [4:0] P_RY   = 5'd11;
  localparam logic [4:0] P_L1   = 5'd12;
  localparam logic [4:0] P_L2   = 5'd13;
  localparam logic [4:0] P_LW   = 5'd14;
  localparam logic [4:0] P_CP   = 5'd15;
  localparam logic [4:0] P_CR   = 5'd16;
  localparam logic [4:0] P_T1   = 5'd17;
  localparam logic [4:0] P_T2   = 5'd18;
  localparam logic [4:0] P_RT   = 5'd19;
  localparam logic [4:0] P_B1   = 5'd20;
  localparam logic [4:0] P_B2   = 5'd21;
  localparam logic [4:0] P_DEC  = 5'd22;

  logic [4:0] pc;
  logic [4:0] pc_next;
  logic       armed;
  logic       armed_next;

  assign in_stall = (pc != P_IDLE);

  always_comb begin
    cmd        = '0;
    pc_next    = pc;
    armed_next = armed;
    unique case (pc)
      P_IDLE: begin
        cmd.in_load = in_valid;
        if (in_valid) pc_next = P_AX;
      end
      P_AX: begin
        cmd.mac_en = 1'b1; cmd.acc_clr = 1'b1; cmd.mac_sel = MAC_AX; pc_next = P_AY;
      end
      P_AY: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_AY; pc_next = P_AZ; end
      P_AZ: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_AZ; pc_next = P_RA; end
      P_GX: begin
        cmd.mac_en = 1'b1; cmd.acc_clr = 1'b1; cmd.mac_sel = MAC_GX; pc_next = P_GY;
      end
      P_GY: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_GY; pc_next = P_GZ; end
      P_GZ: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_GZ; pc_next = P_RG; end
      P_YY: begin
        cmd.mac_en = 1'b1; cmd.acc_clr = 1'b1; cmd.mac_sel = MAC_AY; pc_next = P_YZ;
      end
      P_YZ: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_AZ; pc_next = P_RY; end
      P_L1: begin
        cmd.mac_en = 1'b1; cmd.acc_clr = 1'b1; cmd.mac_sel = MAC_LP; pc_next = P_L2;
      end
      P_L2: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_LPA; pc_next = P_LW; end
      P_LW: begin cmd.lp_write = 1'b1; pc_next = P_CP; end
      P_T1: begin
        cmd.mac_en = 1'b1; cmd.acc_clr = 1'b1; cmd.mac_sel = MAC_PI; pc_next = P_T2;
      end
      P_T2: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_RO; pc_next = P_RT; end
      P_B1: begin
        cmd.mac_en = 1'b1; cmd.acc_clr = 1'b1; cmd.mac_sel = MAC_BL; pc_next = P_B2;
      end
      P_B2: begin cmd.mac_en = 1'b1; cmd.mac_sel = MAC_BT; pc_next = P_DEC; end
      P_RA, P_RG, P_RY, P_RT: begin
        unique case (pc)
          P_RA:    cmd.root_sel = ROOT_ACCEL;
          P_RG:    cmd.root_sel = ROOT_GYRO;
          P_RY:    cmd.root_sel = ROOT_YZ;
          default: cmd.root_sel = ROOT_TILT;
        endcase
        cmd.root_start = !armed;
        armed_next     = 1'b1;
        if (stat.root_done) begin
          armed_next = 1'b0;
          unique case (pc)
            P_RA:    pc_next = P_GX;
            P_RG:    pc_next = P_YY;
            P_RY:    pc_next = P_L1;
            default: pc_next = P_B1;
          endcase
        end
      end
      P_CP, P_CR: begin
        cmd.cord_sel   = (pc == P_CR) ? CORD_ROLL : CORD_PITCH;
        cmd.cord_start = !armed;
        armed_next     = 1'b1;
        if (stat.cord_done) begin
          armed_next = 1'b0;
          pc_next    = (pc == P_CR) ? P_T1 : P_CR;
        end
      end
      P_DEC: begin
        // wait for the result register to be free
        cmd.decide = stat.out_free;
        if (stat.out_free) pc_next = P_IDLE;
      end
      default: pc_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= P_IDLE;
      armed <= 1'b0;
    end else begin
      pc    <= pc_next;
      armed <= armed_next;
    end
  end

`ifndef SYNTHESIS
  a_root_not_instant: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |=> !stat.root_done)
    else $error("square root finished one cycle after start");

  a_root_done_where: assert property (@(posedge clk) disable iff (rst)
    stat.root_done |-> (pc == P_RA || pc == P_RG || pc == P_RY || pc == P_RT))
    else $error("square root result outside a root step");

  a_cord_done_where: assert property (@(posedge clk) disable iff (rst)
    stat.cord_done |-> (pc == P_CP || pc == P_CR))
    else $error("cordic result outside an angle step");

  a_dec_holds: assert property (@(posedge clk) disable iff (rst)
    (pc == P_DEC && !stat.out_free) |=> (pc == P_DEC))
    else $error("decision left while result register full");
`endif

endmodule
`default_nettype wire

### sv/imu_fall_detector_core.sv
// top level of the imu fall detector: register port, controller and datapath
//
//  channel  | handshake             | contents
//  ---------+-----------------------+---------------------------------------------
//  sample   | in_valid / in_stall   | accel, gyro, time_ms, manual_mode, clear_alarm
//  result   | out_valid / out_stall | flags, filtered_accel, angles, cancel_reason
//  config   | psel/penable/pwrite   | seven threshold registers at 4*index
//
// one sample at a time; the time from transfer to result is set by the serial
// square root unit (one bit per cycle, four roots per sample) and the two cordic
// passes (one rotation per cycle).
// a new sample is taken while a finished result waits; the last step holds
// until the result register is free. reset is synchronous and loads the
// register defaults and the detector state.
`default_nettype none
module imu_fall_detector_core import ifd_pkg::*; #(
  parameter int PEAK_WINDOW_MS   = 500,
  parameter int DECIDE_MS        = 2500,
  parameter int FREEFALL_HOLD_MS = 1000,
  parameter int CORDIC_STEPS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] gyro_x,
  input  wire logic signed [15:0] gyro_y,
  input  wire logic signed [15:0] gyro_z,
  input  wire logic [31:0]        time_ms,
  input  wire logic               manual_mode,
  input  wire logic               clear_alarm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    fall_confirmed,
  output logic                    fall_event,
  output logic                    impact_active,
  output logic                    freefall_active,
  output logic                    immobile,
  output logic [15:0]             filtered_accel,
  output logic [14:0]             tilt_angle,
  output logic [14:0]             baseline_angle,
  output logic [1:0]              cancel_reason,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freefall_level              <= 16'd3277;
      cfg.impact_level                <= 16'd20480;
      cfg.impact_after_freefall_level <= 16'd16384;
      cfg.peak_rotation_level         <= 16'd9825;
      cfg.angle_change_level          <= 15'd3840;
      cfg.accel_swing_limit           <= 16'd12288;
      cfg.angle_swing_limit           <= 15'd7680;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FREEFALL:     cfg.freefall_level              <= pwdata[15:0];
        REG_IMPACT:       cfg.impact_level                <= pwdata[15:0];
        REG_IMPACT_AFTER: cfg.impact_after_freefall_level <= pwdata[15:0];
        REG_PEAK_ROT:     cfg.peak_rotation_level         <= pwdata[15:0];
        REG_ANGLE_CHANGE: cfg.angle_change_level          <= pwdata[14:0];
        REG_ACCEL_SWING:  cfg.accel_swing_limit           <= pwdata[15:0];
        REG_ANGLE_SWING:  cfg.angle_swing_limit           <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FREEFALL:     prdata = {16'h0000, cfg.freefall_level};
      REG_IMPACT:       prdata = {16'h0000, cfg.impact_level};
      REG_IMPACT_AFTER: prdata = {16'h0000, cfg.impact_after_freefall_level};
      REG_PEAK_ROT:     prdata = {16'h0000, cfg.peak_rotation_level};
      REG_ANGLE_CHANGE: prdata = {17'h00000, cfg.angle_change_level};
      REG_ACCEL_SWING:  prdata = {16'h0000, cfg.accel_swing_limit};
      REG_ANGLE_SWING:  prdata = {17'h00000, cfg.angle_swing_limit};
      default:          prdata = '0;
    endcase
  end

  ifd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  ifd_dp #(
    .PEAK_WINDOW_MS   (PEAK_WINDOW_MS),
    .DECIDE_MS        (DECIDE_MS),
    .FREEFALL_HOLD_MS (FREEFALL_HOLD_MS),
    .CORDIC_STEPS     (CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .accel_z         (accel_z),
    .gyro_x          (gyro_x),
    .gyro_y          (gyro_y),
    .gyro_z          (gyro_z),
    .time_ms         (time_ms),
    .manual_mode     (manual_mode),
    .clear_alarm     (clear_alarm),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .fall_confirmed  (fall_confirmed),
    .fall_event      (fall_event),
    .impact_active   (impact_active),
    .freefall_active (freefall_active),
    .immobile        (immobile),
    .filtered_accel  (filtered_accel),
    .tilt_angle      (tilt_angle),
    .baseline_angle  (baseline_angle),
    .cancel_reason   (cancel_reason)
  );

endmodule
`default_nettype wire

### tb/imu_fall_detector_core_tb.sv
// testbench for the imu fall detector core: fixed-point predictor, random samples, apb writes
`timescale 1ns / 1ps
`default_nettype none

class fall_scoreboard;
  // detector thresholds
  int unsigned freefall_lvl, impact_lvl, impact_ff_lvl, peak_rot_lvl;
  int unsigned angle_chg_lvl, accel_swing_lim, angle_swing_lim;
  // detector state
  int unsigned lowpass, baseline, rot_peak;
  int unsigned sw_acc_max, sw_acc_min, sw_ang_max, sw_ang_min;
  bit tracking, pending, latched, ff_seen, still;
  bit [31:0] ff_stamp, impact_stamp;
  // fc, fe, ia, fa, im, filtered[16], tilt[15], baseline[15], cancel[2]
  logic [52:0] due_q[$];
  int errors;
  int falls, cancels;

  function new();
    freefall_lvl = 3277; impact_lvl = 20480; impact_ff_lvl = 16384;
    peak_rot_lvl = 9825; angle_chg_lvl = 3840;
    accel_swing_lim = 12288; angle_swing_lim = 7680;
    lowpass = 8192; baseline = 0; rot_peak = 0;
    sw_acc_max = 0; sw_acc_min = 0; sw_ang_max = 0; sw_ang_min = 0;
    tracking = 0; pending = 0; latched = 0; ff_seen = 0; still = 0;
    ff_stamp = 0; impact_stamp = 0;
    errors = 0; falls = 0; cancels = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      ifd_pkg::REG_FREEFALL:     freefall_lvl = v[15:0];
      ifd_pkg::REG_IMPACT:       impact_lvl = v[15:0];
      ifd_pkg::REG_IMPACT_AFTER: impact_ff_lvl = v[15:0];
      ifd_pkg::REG_PEAK_ROT:     peak_rot_lvl = v[15:0];
      ifd_pkg::REG_ANGLE_CHANGE: angle_chg_lvl = v[14:0];
      ifd_pkg::REG_ACCEL_SWING:  accel_swing_lim = v[15:0];
      ifd_pkg::REG_ANGLE_SWING:  angle_swing_lim = v[14:0];
      default: ;
    endcase
  endfunction

  static function longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // vectoring cordic, result in 1/128 degree
  static function longint angle_of(longint y, longint x, int steps);
    longint z, nx, ny, m, r;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = 90 * 65536;
      end else begin
        nx = -y; ny = x; z = -90 * 65536;
      end
      x = nx; y = ny;
    end
    for (int i = 0; i < steps && i < 24; i++) begin
      if (y > 0) begin
        nx = x + floor_shift(y, i); ny = y - floor_shift(x, i);
        z = z + longint'(ifd_pkg::atan_step(i[4:0]));
      end else begin
        nx = x - floor_shift(y, i); ny = y + floor_shift(x, i);
        z = z - longint'(ifd_pkg::atan_step(i[4:0]));
      end
      x = nx; y = ny;
    end
    m = (z < 0) ? -z : z;
    r = (m + 256) >>> 9;
    return (z < 0) ? -r : r;
  endfunction

  // predicts the result of one accepted sample and queues it
  function void note_sample(logic signed [15:0] ax, ay, az, gx, gy, gz,
                            logic [31:0] now, logic manual, logic clr,
                            int peak_ms, int decide_ms, int hold_ms, int steps);
    longint unsigned acc, gyr, t, yz;
    longint pitch, roll;
    int unsigned tilt, ga, gb, diff;
    bit [31:0] dt;
    logic [1:0] cancel;
    bit ev, quiet;
    cancel = ifd_pkg::CANCEL_NONE; ev = 0;
    if (clr) begin
      latched = 0; pending = 0; tracking = 0;
    end
    acc = int_root(longint'(ax)*ax + longint'(ay)*ay + longint'(az)*az);
    gyr = int_root(longint'(gx)*gx + longint'(gy)*gy + longint'(gz)*gz);
    lowpass = 32'((64'd55706 * lowpass + 64'd9830 * acc + 32768) >> 16);
    yz = int_root((longint'(ay)*ay + longint'(az)*az) << 16);
    pitch = angle_of(-longint'(ax) * 256, longint'(yz), steps);
    roll = angle_of(longint'(ay) * 256, longint'(az) * 256, steps);
    t = int_root(pitch * pitch + roll * roll);
    tilt = (t > 32767) ? 32767 : 32'(t);
    if (!pending && !latched && acc > 6553 && acc < 9831 && gyr < 3275)
      baseline = 32'((64'd62259 * baseline + 64'd3277 * tilt + 32768) >> 16);
    still = !manual && lowpass > 7536 && lowpass < 8848 && !pending && !latched;
    if (!latched) begin
      if (acc < freefall_lvl) begin
        ff_seen = 1; ff_stamp = now;
      end
      if (ff_seen && (now - ff_stamp) > hold_ms) ff_seen = 0;
      if (!pending && (acc > impact_lvl || (ff_seen && acc > impact_ff_lvl))) begin
        pending = 1; impact_stamp = now; ff_seen = 0; rot_peak = 32'(gyr); tracking = 0;
      end
    end
    if (pending && !latched) begin
      dt = now - impact_stamp;
      if (dt <= peak_ms && gyr > rot_peak) rot_peak = 32'(gyr);
      if (dt > peak_ms && !tracking) begin
        tracking = 1;
        sw_acc_max = lowpass; sw_acc_min = lowpass; sw_ang_max = tilt; sw_ang_min = tilt;
      end
      if (tracking) begin
        if (lowpass > sw_acc_max) sw_acc_max = lowpass;
        if (lowpass < sw_acc_min) sw_acc_min = lowpass;
        if (tilt > sw_ang_max) sw_ang_max = tilt;
        if (tilt < sw_ang_min) sw_ang_min = tilt;
      end
      if (dt > decide_ms) begin
        ga = (sw_acc_max > sw_acc_min) ? sw_acc_max - sw_acc_min : 0;
        gb = (sw_ang_max > sw_ang_min) ? sw_ang_max - sw_ang_min : 0;
        quiet = ga < accel_swing_lim && gb < angle_swing_lim && lowpass > 5734 && lowpass < 10650;
        if (!quiet) cancel = ifd_pkg::CANCEL_MOTION;
        else if (rot_peak <= peak_rot_lvl) cancel = ifd_pkg::CANCEL_SLOW_ROT;
        else begin
          diff = (tilt > baseline) ? tilt - baseline : baseline - tilt;
          if (diff > angle_chg_lvl) begin
            latched = 1; ev = 1; falls++;
          end else begin
            cancel = ifd_pkg::CANCEL_SMALL_ANGLE;
          end
        end
        if (cancel != ifd_pkg::CANCEL_NONE) begin
          pending = 0; cancels++;
        end
      end
    end
    due_q.push_back({latched, ev, pending, ff_seen, still, lowpass[15:0], tilt[14:0],
                     baseline[14:0], cancel});
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic fc, fe, ia, fa, im, logic [15:0] fac,
                    logic [14:0] ta, ba, logic [1:0] cr);
    logic [52:0] w;
    if (due_q.size() == 0) begin
      report("unexpected result", 0, 0);
      return;
    end
    w = due_q.pop_front();
    if (fc !== w[52]) report("fall_confirmed", 64'(fc), 64'(w[52]));
    if (fe !== w[51]) report("fall_event", 64'(fe), 64'(w[51]));
    if (ia !== w[50]) report("impact_active", 64'(ia), 64'(w[50]));
    if (fa !== w[49]) report("freefall_active", 64'(fa), 64'(w[49]));
    if (im !== w[48]) report("immobile", 64'(im), 64'(w[48]));
    if (fac !== w[47:32]) report("filtered_accel", 64'(fac), 64'(w[47:32]));
    if (ta !== w[31:17]) report("tilt_angle", 64'(ta), 64'(w[31:17]));
    if (ba !== w[16:2]) report("baseline_angle", 64'(ba), 64'(w[16:2]));
    if (cr !== w[1:0]) report("cancel_reason", 64'(cr), 64'(w[1:0]));
  endtask
endclass

module imu_fall_detector_core_tb;
  import ifd_pkg::*;

  localparam int PEAK_MS = 500;
  localparam int DECIDE_MS = 2500;
  localparam int HOLD_MS = 1000;
  localparam int STEPS = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM = 800;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall;
  logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic signed [15:0] gyro_x = 0, gyro_y = 0, gyro_z = 0;
  logic [31:0] time_ms = 0;
  logic manual_mode = 0, clear_alarm = 0;
  logic out_valid, out_stall = 0;
  logic fall_confirmed, fall_event, impact_active, freefall_active, immobile;
  logic [15:0] filtered_accel;
  logic [14:0] tilt_angle, baseline_angle;
  logic [1:0] cancel_reason;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  imu_fall_detector_core #(
    .PEAK_WINDOW_MS(PEAK_MS), .DECIDE_MS(DECIDE_MS),
    .FREEFALL_HOLD_MS(HOLD_MS), .CORDIC_STEPS(STEPS)
  ) dut (.*);

  always #4 clk = ~clk;

  fall_scoreboard fall_sb = new();
  int send_idle_pct = 37, recv_idle_pct = 47;
  int idle_cycles = 0;
  int samples_sent = 0, results_seen = 0;
  bit done = 0;
  logic [31:0] clock_ms = 0;

  // receiver: random stall, check on transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      fall_sb.check_result(fall_confirmed, fall_event, impact_active, freefall_active,
                           immobile, filtered_accel, tilt_angle, baseline_angle,
                           cancel_reason);
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    fall_sb.set_reg(idx, v);
  endtask

  task automatic send_sample(logic signed [15:0] ax, ay, az, gx, gy, gz,
                             logic [31:0] now, logic manual, logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
    time_ms <= now; manual_mode <= manual; clear_alarm <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fall_sb.note_sample(ax, ay, az, gx, gy, gz, now, manual, clr,
                        PEAK_MS, DECIDE_MS, HOLD_MS, STEPS);
    samples_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (fall_sb.due_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // one fall scenario with random content: still, free fall, impact, rest
  task automatic fall_story();
    int base_t;
    int rot, ang;
    rot = $urandom_range(20000);
    ang = $urandom_range(8000);
    for (int i = 0; i < 3; i++) begin
      clock_ms += $urandom_range(50, 300);
      send_sample($urandom_range(400) - 200, $urandom_range(400) - 200,
                  8192 + $urandom_range(200) - 100, $urandom_range(200) - 100, 0, 0,
                  clock_ms, 0, 0);
    end
    clock_ms += $urandom_range(50, 200);
    send_sample($urandom_range(1000) - 500, 0, $urandom_range(2000), 0, 0, 0,
                clock_ms, $urandom_range(1), 0);
    clock_ms += $urandom_range(20, 900);
    send_sample(20000 + $urandom_range(12000), $urandom_range(4000), 0,
                rot, $urandom_range(2000), 0, clock_ms, 0, 0);
    base_t = $urandom_range(4, 10);
    for (int i = 0; i < base_t; i++) begin
      clock_ms += $urandom_range(100, 600);
      send_sample(ang, $urandom_range(600) - 300,
                  ($urandom_range(1) ? 1 : -1) * (8192 - ang / 2),
                  $urandom_range(100), 0, 0, clock_ms, 0, ($urandom_range(30) == 0));
    end
  endtask

  logic [31:0] t_tmp;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: field extremes, atan corners, timestamp wrap
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                32'hffff_ff00, 0, 0);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                32'hffff_ff10, 1, 1);
    send_sample(0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0, 0);
    send_sample(0, 0, -8192, 0, 0, 0, 32'd5, 0, 0);
    send_sample(0, 8192, 0, 0, 0, 0, 32'd700, 0, 0);
    send_sample(0, -8192, 0, 0, 0, 0, 32'd900, 0, 0);
    send_sample(8192, 0, 0, 0, 0, 0, 32'd1100, 0, 0);
    send_sample(0, 0, 8192, 0, 0, 0, 32'd3800, 0, 0);
    send_sample(16'sh5555, -16'sh2aab, 16'sh1234, 16'sh2aaa, -16'sh5556, 16'sh0f0f,
                32'haaaa_5555, 1, 1);
    send_sample(0, 0, 8192, 0, 0, 0, 32'h5555_aaaa, 0, 0);
    clock_ms = 32'h5555_b000;
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 47; recv_idle_pct = 37;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // thresholds: reset values, random, extremes
      case (phase)
        0: begin
          reg_write(REG_FREEFALL, 32'hffff_0000 | 32'd3277);
          reg_write(REG_IMPACT, 32'd20480);
          reg_write(REG_IMPACT_AFTER, 32'd16384);
          reg_write(REG_PEAK_ROT, 32'd9825);
          reg_write(REG_ANGLE_CHANGE, 32'd3840);
          reg_write(REG_ACCEL_SWING, 32'd12288);
          reg_write(REG_ANGLE_SWING, 32'd7680);
        end
        1: begin
          reg_write(REG_FREEFALL, $urandom_range(6000));
          reg_write(REG_IMPACT, $urandom_range(16000, 40000));
          reg_write(REG_IMPACT_AFTER, $urandom_range(9000, 20000));
          reg_write(REG_PEAK_ROT, $urandom_range(15000));
          reg_write(REG_ANGLE_CHANGE, $urandom_range(6000));
          reg_write(REG_ACCEL_SWING, $urandom_range(4000, 30000));
          reg_write(REG_ANGLE_SWING, $urandom_range(3000, 20000));
        end
        default: begin
          reg_write(REG_FREEFALL, 32'hffff);
          reg_write(REG_IMPACT, 32'hffff);
          reg_write(REG_IMPACT_AFTER, 32'd0);
          reg_write(REG_PEAK_ROT, 32'd0);
          reg_write(REG_ANGLE_CHANGE, 32'd0);
          reg_write(REG_ACCEL_SWING, 32'hffff);
          reg_write(REG_ANGLE_SWING, 32'h7fff);
        end
      endcase
      while (samples_sent < 10 + (phase + 1) * N_RANDOM / 3) begin
        if ($urandom_range(3) != 0) fall_story();
        else begin
          clock_ms += $urandom_range(1, 2000);
          t_tmp = ($urandom_range(40) == 0) ? $urandom : clock_ms;
          send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      t_tmp, $urandom_range(1), $urandom_range(1));
        end
      end
      drain();
    end
    done = 1;
    $display("%0d samples checked, %0d results, %0d falls, %0d cancelled windows",
             samples_sent, results_seen, fall_sb.falls, fall_sb.cancels);
    $display("three threshold sets including the extremes, with and without handshake stalls");
    if (fall_sb.errors == 0 && fall_sb.due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
